/* src/sre_pkg.sv */
// Shared types and constants for the subpicture run-length encoder.
// Used by the controller, the datapath and the top level; depends on nothing.

package sre_pkg;

  localparam int MAX_LINE_WIDTH = 1024;
  localparam int MAP_ENTRIES    = 256;

  localparam int MAP_AW = $clog2(MAP_ENTRIES);
  localparam int RUN_W  = $clog2(MAX_LINE_WIDTH + 1);
  localparam int CMP_W  = 13;

  localparam int LW_W   = 11;
  localparam int ROWS_W = 12;
  localparam int CFG_W  = 12;
  localparam int IDX_W  = 8;
  localparam int COLR_W = 2;
  localparam int NIB_W  = 4;
  localparam int BYTE_W = 8;

  localparam logic [LW_W-1:0]   LINE_WIDTH_RST = 11'd720;
  localparam logic [ROWS_W-1:0] ROWS_RST       = 12'd288;

  // Run length thresholds of the nibble code.
  localparam logic [CMP_W-1:0] LEN_ONE_NIB  = 13'h004;
  localparam logic [CMP_W-1:0] LEN_TWO_NIB  = 13'h010;
  localparam logic [CMP_W-1:0] LEN_FILL_MIN = 13'h040;
  localparam logic [CMP_W-1:0] CHUNK_MAX    = 13'h0ff;
  localparam logic [7:0]       CHUNK_CODE   = 8'hff;

  typedef enum logic {
    KIND_MAP   = 1'b0,
    KIND_PIXEL = 1'b1
  } kind_e;

  typedef enum logic {
    REG_LINE_WIDTH    = 1'b0,
    REG_ROWS_IN_FIELD = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic accept_map;
    logic accept_pix;
    logic step;
    logic at_end;
    logic load_b;
    logic pad;
    logic flush;
  } sre_cmd_t;

  typedef struct packed {
    logic need_a;
    logic eol_now;
    logic eol_q;
    logic run_done;
    logic out_free;
  } sre_status_t;

endpackage

/* src/sre_ctrl.sv */
// Controller state machine of the subpicture run-length encoder.
// Depends on sre_pkg; drives the datapath through sre_cmd_t.

module sre_ctrl import sre_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        kind_i,
  output logic        in_stall_o,
  input  sre_status_t sts_i,
  output sre_cmd_t    cmd_o
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_RUN_A = 5'b00010,
    ST_RUN_B = 5'b00100,
    ST_PAD   = 5'b01000,
    ST_FLUSH = 5'b10000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.accept_map = in_valid_i && (kind_i == KIND_MAP);
        cmd_o.accept_pix = in_valid_i && (kind_i == KIND_PIXEL);
        if (cmd_o.accept_pix) begin
          if (sts_i.need_a) begin
            state_d = ST_RUN_A;
          end else if (sts_i.eol_now) begin
            state_d = ST_RUN_B;
          end
        end
      end
      ST_RUN_A: begin
        // The run that the new pixel breaks off.
        cmd_o.step = sts_i.out_free;
        if (sts_i.out_free && sts_i.run_done) begin
          if (sts_i.eol_q) begin
            cmd_o.load_b = 1'b1;
            state_d      = ST_RUN_B;
          end else begin
            state_d = ST_FLUSH;
          end
        end
      end
      ST_RUN_B: begin
        // The run that reaches the end of the line.
        cmd_o.at_end = 1'b1;
        cmd_o.step   = sts_i.out_free;
        if (sts_i.out_free && sts_i.run_done) begin
          state_d = ST_PAD;
        end
      end
      ST_PAD: begin
        cmd_o.pad = sts_i.out_free;
        if (sts_i.out_free) begin
          state_d = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        cmd_o.flush = sts_i.out_free;
        if (sts_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);

endmodule

/* src/sre_datapath.sv */
// Datapath of the subpicture run-length encoder: colour map, line and run
// counters, nibble coder, byte packer and output register. Depends on sre_pkg.

module sre_datapath import sre_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [0:0]          cfg_addr_i,
  input  logic [CFG_W-1:0]    cfg_data_i,
  input  logic [IDX_W-1:0]    pixel_index_i,
  input  logic [COLR_W-1:0]   map_value_i,
  input  sre_cmd_t            cmd_i,
  output sre_status_t         sts_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [BYTE_W-1:0]   out_byte_o,
  output logic                line_end_o,
  output logic                field_end_o,
  output logic                last_o
);

  logic [LW_W-1:0]   line_width_q;
  logic [ROWS_W-1:0] rows_q;

  logic [IDX_W-1:0]  run_value_q;
  logic [RUN_W-1:0]  run_len_q;
  logic [RUN_W-1:0]  column_q;
  logic [ROWS_W-1:0] row_q;

  logic [COLR_W-1:0] map_mem [MAP_ENTRIES];
  logic [COLR_W-1:0] rd_a_q, rd_b_q;
  logic              ok_a_q, ok_b_q;

  logic [RUN_W-1:0]  rem_q, b_len_q;
  logic [1:0]        nib_pos_q;
  logic              eol_q, fend_q;

  logic              pend_q;
  logic [NIB_W-1:0]  held_q;
  logic [BYTE_W-1:0] stage_q;
  logic              stage_vld_q;
  logic              out_vld_q;

  // Item decode.
  logic [CMP_W-1:0] lw_ext, w_eff, col_next, rows_eff, row_next, new_len_x;
  logic             need_a, eol_now, fend_now, idx_in_map, old_in_map;

  always_comb begin
    lw_ext    = CMP_W'(line_width_q);
    if (lw_ext == '0) begin
      w_eff = CMP_W'(1);
    end else if (lw_ext > CMP_W'(MAX_LINE_WIDTH)) begin
      w_eff = CMP_W'(MAX_LINE_WIDTH);
    end else begin
      w_eff = lw_ext;
    end
    rows_eff  = (rows_q == '0) ? CMP_W'(1) : CMP_W'(rows_q);
    row_next  = CMP_W'(row_q) + CMP_W'(1);
    col_next  = CMP_W'(column_q) + CMP_W'(1);
    need_a    = (run_len_q != '0) && (pixel_index_i != run_value_q);
    new_len_x = need_a ? CMP_W'(1) : (CMP_W'(run_len_q) + CMP_W'(1));
    eol_now   = (col_next >= w_eff);
    fend_now  = eol_now && (row_next >= rows_eff);
    idx_in_map = ({1'b0, pixel_index_i} < (IDX_W + 1)'(MAP_ENTRIES));
    old_in_map = ({1'b0, run_value_q} < (IDX_W + 1)'(MAP_ENTRIES));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_width_q <= LINE_WIDTH_RST;
      rows_q       <= ROWS_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_LINE_WIDTH:    line_width_q <= cfg_data_i[LW_W-1:0];
        REG_ROWS_IN_FIELD: rows_q       <= cfg_data_i[ROWS_W-1:0];
        default:           rows_q       <= rows_q;
      endcase
    end
  end

  // Colour map: one write port, two registered read ports used at pixel accept.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept_map && idx_in_map) begin
      map_mem[pixel_index_i[MAP_AW-1:0]] <= map_value_i;
    end
    if (cmd_i.accept_pix) begin
      rd_a_q <= map_mem[run_value_q[MAP_AW-1:0]];
      rd_b_q <= map_mem[pixel_index_i[MAP_AW-1:0]];
      ok_a_q <= old_in_map;
      ok_b_q <= idx_in_map;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_value_q <= '0;
      run_len_q   <= '0;
      column_q    <= '0;
      row_q       <= '0;
    end else if (cmd_i.accept_pix) begin
      run_value_q <= pixel_index_i;
      if (eol_now) begin
        run_len_q <= '0;
        column_q  <= '0;
        row_q     <= fend_now ? '0 : ROWS_W'(row_next);
      end else begin
        run_len_q <= RUN_W'(new_len_x);
        column_q  <= RUN_W'(col_next);
      end
    end
  end

  // Nibble coder. A fill code is a four-nibble code with a zero length field.
  logic [CMP_W-1:0]  rem_ext;
  logic              fill, big, chunk_done;
  logic [7:0]        code_len;
  logic [1:0]        nib_last, nib_sel;
  logic [COLR_W-1:0] colour;
  logic [NIB_W-1:0]  nib;

  always_comb begin
    rem_ext  = CMP_W'(rem_q);
    fill     = cmd_i.at_end && (rem_ext >= LEN_FILL_MIN);
    big      = !cmd_i.at_end && (rem_ext > CHUNK_MAX);
    colour   = cmd_i.at_end ? (ok_b_q ? rd_b_q : '0) : (ok_a_q ? rd_a_q : '0);
    if (big) begin
      code_len = CHUNK_CODE;
    end else if (fill) begin
      code_len = '0;
    end else begin
      code_len = rem_ext[7:0];
    end
    priority if (fill || big) begin
      nib_last = 2'd3;
    end else if (rem_ext < LEN_ONE_NIB) begin
      nib_last = 2'd0;
    end else if (rem_ext < LEN_TWO_NIB) begin
      nib_last = 2'd1;
    end else if (rem_ext < LEN_FILL_MIN) begin
      nib_last = 2'd2;
    end else begin
      nib_last = 2'd3;
    end
    nib_sel = nib_last - nib_pos_q;
    unique case (nib_sel)
      2'd0:    nib = {code_len[1:0], colour};
      2'd1:    nib = code_len[5:2];
      2'd2:    nib = {2'b00, code_len[7:6]};
      default: nib = '0;
    endcase
    chunk_done = (nib_pos_q == nib_last);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nib_pos_q <= '0;
    end else if (cmd_i.accept_pix || cmd_i.load_b) begin
      nib_pos_q <= '0;
    end else if (cmd_i.step) begin
      nib_pos_q <= chunk_done ? 2'd0 : (nib_pos_q + 2'd1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept_pix) begin
      rem_q   <= need_a ? run_len_q : RUN_W'(new_len_x);
      b_len_q <= RUN_W'(new_len_x);
      eol_q   <= eol_now;
      fend_q  <= fend_now;
    end else if (cmd_i.load_b) begin
      rem_q <= b_len_q;
    end else if (cmd_i.step && chunk_done && big) begin
      rem_q <= RUN_W'(rem_ext - CHUNK_MAX);
    end
  end

  // Byte packer. A finished byte waits in the stage register until the next
  // byte or the end of the item shows whether it is the item's last.
  logic              nib_v, push_mid, push_fin;
  logic [NIB_W-1:0]  nib_in;

  assign nib_v    = cmd_i.step || (cmd_i.pad && pend_q);
  assign nib_in   = cmd_i.pad ? '0 : nib;
  assign push_mid = nib_v && pend_q && stage_vld_q;
  assign push_fin = cmd_i.flush && stage_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= 1'b0;
      held_q      <= '0;
      stage_vld_q <= 1'b0;
      out_vld_q   <= 1'b0;
    end else begin
      if (nib_v) begin
        pend_q <= !pend_q;
        held_q <= pend_q ? '0 : nib_in;
      end
      if (nib_v && pend_q) begin
        stage_vld_q <= 1'b1;
      end else if (push_fin) begin
        stage_vld_q <= 1'b0;
      end
      if (push_mid || push_fin) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (nib_v && pend_q) begin
      stage_q <= {held_q, nib_in};
    end
    if (push_mid) begin
      out_byte_o  <= stage_q;
      line_end_o  <= 1'b0;
      field_end_o <= 1'b0;
      last_o      <= 1'b0;
    end else if (push_fin) begin
      out_byte_o  <= stage_q;
      line_end_o  <= eol_q;
      field_end_o <= fend_q;
      last_o      <= 1'b1;
    end
  end

  assign out_valid_o = out_vld_q;

  always_comb begin
    sts_o          = '0;
    sts_o.need_a   = need_a;
    sts_o.eol_now  = eol_now;
    sts_o.eol_q    = eol_q;
    sts_o.run_done = chunk_done && !big;
    sts_o.out_free = !out_vld_q || !out_stall_i;
  end

endmodule

/* src/subpicture_rle_encoder_unit.sv */
// Subpicture run-length encoder, 2-bit colours: 8-bit palette pixels in,
// packed nibble-code bytes out. A map-load item and a pixel item that finishes
// no run are taken without a stall. A pixel that finishes a run is accepted,
// then each finished run is coded as one to four nibbles per chunk of up to
// 255 pixels, a line end adds the pad step, and the item's last byte is
// released. The coder produces one nibble per cycle while the output is not
// stalled. The next item is taken once all work of the current one
// is done. The colour map holds no reset value; every entry read must be
// loaded first. Depends on sre_pkg, sre_ctrl and sre_datapath.

module subpicture_rle_encoder_unit import sre_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [0:0]          cfg_addr_i,
  input  logic [CFG_W-1:0]    cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                kind_i,
  input  logic [IDX_W-1:0]    pixel_index_i,
  input  logic [COLR_W-1:0]   map_value_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [BYTE_W-1:0]   out_byte_o,
  output logic                line_end_o,
  output logic                field_end_o,
  output logic                last_o
);

  sre_cmd_t    cmd;
  sre_status_t sts;

  sre_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .kind_i     (kind_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  sre_datapath u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_data_i    (cfg_data_i),
    .pixel_index_i (pixel_index_i),
    .map_value_i   (map_value_i),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_byte_o    (out_byte_o),
    .line_end_o    (line_end_o),
    .field_end_o   (field_end_o),
    .last_o        (last_o)
  );

endmodule

/* src/sre_checker.sv */
// Port-level checks for the subpicture run-length encoder, and the bind that
// attaches them to subpicture_rle_encoder_unit. Depends on sre_pkg.

module sre_checker import sre_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_stall_o,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input logic [BYTE_W-1:0] out_byte_o,
  input logic              line_end_o,
  input logic              field_end_o,
  input logic              last_o
);

  // A byte that is held back keeps its place and its contents.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_byte_o) && $stable(last_o))
    else $error("stalled output item changed");

  // A line ends only on the last byte of an item.
  a_line_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && line_end_o |-> last_o)
    else $error("line end on a byte that is not the last of its item");

  // A field ends only where a line ends.
  a_field_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && field_end_o |-> line_end_o)
    else $error("field end without line end");

  // Bytes are only produced while an item is being worked on.
  a_out_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("output item appeared while the block was idle");

endmodule

bind subpicture_rle_encoder_unit sre_checker u_sre_checker (.*);
